/* hdl/kclc_pkg.sv */
// ----------------------------------------------------------------------------
// kclc_pkg
// Shared types, codes and tables for the keypad code lock controller.
// ----------------------------------------------------------------------------
package kclc_pkg;

  localparam int unsigned CodeDigitsDef = 4;

  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 40;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_CODE_WORD     = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_WAIT_TICKS    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_FLASH_REPEATS = 2'd2;

  localparam logic [15:0] CodeWordRst     = 16'h7298;
  localparam logic [3:0]  WaitTicksRst    = 4'd4;
  localparam logic [2:0]  FlashRepeatsRst = 3'd3;

  localparam logic [3:0] KeyBlank = 4'd15;

  typedef enum logic [2:0] {
    ST_START = 3'd0,
    ST_INPUT = 3'd1,
    ST_WAIT  = 3'd2,
    ST_OPEN  = 3'd3,
    ST_NO    = 3'd4
  } lock_state_e;

  typedef enum logic [2:0] {
    DISP_ALL   = 3'd0,
    DISP_WALK  = 3'd1,
    DISP_BLANK = 3'd2,
    DISP_DIGIT = 3'd3,
    DISP_OPEN  = 3'd4,
    DISP_NO    = 3'd5
  } disp_mode_e;

  typedef enum logic [2:0] {
    TONE_OFF = 3'd0,
    TONE_440 = 3'd1,
    TONE_880 = 3'd2,
    TONE_523 = 3'd3,
    TONE_370 = 3'd4,
    TONE_554 = 3'd5,
    TONE_659 = 3'd6
  } tone_e;

  // segment order F, A, B, C, D, E, G
  localparam logic [6:0] WalkCodes [7] = '{
    7'h20, 7'h01, 7'h02, 7'h04, 7'h08, 7'h10, 7'h40
  };

  typedef struct packed {
    logic       done_signal;
    logic       relay_on;
    tone_e      tone_select;
    logic [6:0] walk_segments;
    logic [1:0] walk_digit;
    logic [15:0] shown_digits;
    disp_mode_e display_mode;
  } result_t;

endpackage

/* hdl/keypad_code_lock_controller_core.sv */
// ----------------------------------------------------------------------------
// keypad_code_lock_controller_core
// Code lock sequencer: self test, key entry, compare, open and reject.
//
//   channel   | dir | handshake              | payload
//   ----------+-----+------------------------+-----------------------------
//   tick in   | in  | s_axis_tvalid/tready   | key_down, key_value, override
//   result out| out | m_axis_tvalid/tready   | display, tone, relay, done
//   config    | in  | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// One item per cycle; each accepted tick yields one result, which is registered
// in the output register and presented in the cycle after. Ready is held low only while that register is
// full and not taken. Reset puts the lock in self test with the default
// code, entry blank and the output register empty.
// ----------------------------------------------------------------------------
module keypad_code_lock_controller_core #(
  parameter int unsigned CODE_DIGITS = kclc_pkg::CodeDigitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // key_down[0], key_value[4:1], override[5], zero[7:6]
  input  logic [kclc_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // display_mode[2:0], shown_digits[18:3], walk_digit[20:19],
  // walk_segments[27:21], tone_select[30:28], relay_on[31],
  // done_signal[32], zero[39:33]
  output logic [kclc_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [kclc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [kclc_pkg::CfgDataW-1:0] cfg_data_i
);
  import kclc_pkg::*;

  localparam int unsigned EcW = $clog2(CODE_DIGITS + 1);

  logic [15:0] code_word_q;
  logic [3:0]  wait_ticks_q;
  logic [2:0]  flash_repeats_q;

  lock_state_e state_q, state_d, cur_state;
  logic [7:0]  elapsed_q, elapsed_d, e_base, e;
  logic [3:0]  keys_q [CODE_DIGITS];
  logic [3:0]  keys_d [CODE_DIGITS];
  logic [EcW-1:0] ec_q, ec_d;
  logic        held_q, held_d;
  logic [2:0]  fc_q, fc_d, fc_nxt;
  logic        lit_q, lit_d, lit_nxt;
  logic        rsd_q, rsd_d;
  logic [8:0]  walk_q, walk_d;

  logic        s_acc, ov_open, press, flip, no_exit, match;
  logic [5:0]  walk_a;
  logic [4:0]  walk_n;
  logic [10:0] walk_prod;
  logic [1:0]  walk_dig;
  logic [2:0]  walk_rem;
  logic [15:0] shown;
  disp_mode_e  disp;
  tone_e       tone;
  logic        relay;
  result_t     res;

  logic        m_valid_q;
  logic [OutDataW-1:0] m_data_q;

  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_word_q     <= CodeWordRst;
      wait_ticks_q    <= WaitTicksRst;
      flash_repeats_q <= FlashRepeatsRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CODE_WORD:     code_word_q     <= cfg_data_i;
        CFG_WAIT_TICKS:    wait_ticks_q    <= cfg_data_i[3:0];
        CFG_FLASH_REPEATS: flash_repeats_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  assign ov_open   = s_axis_tdata[5] && (state_q != ST_OPEN);
  assign cur_state = ov_open ? ST_OPEN : state_q;
  assign e_base    = ov_open ? 8'd0 : elapsed_q;
  assign e         = (e_base == 8'hFF) ? e_base : e_base + 8'd1;
  assign press     = s_axis_tdata[0] && !held_q;

  assign flip    = (e[2:0] == 3'd0);
  assign lit_nxt = flip ? !lit_q : lit_q;
  assign fc_nxt  = (flip && !lit_nxt && fc_q < 3'd7) ? fc_q + 3'd1 : fc_q;
  assign no_exit = (fc_nxt >= flash_repeats_q) && !lit_nxt;

  // segment walk step: n / 7 by reciprocal, n < 28
  assign walk_a    = 6'(e - 8'd20);
  assign walk_n    = walk_a[5:1];
  assign walk_prod = 11'(walk_n) * 11'd37;
  assign walk_dig  = walk_prod[9:8];
  assign walk_rem  = 3'(walk_n - 5'(walk_dig) * 5'd7);

  always_comb begin
    match = 1'b1;
    for (int i = 0; i < CODE_DIGITS; i++) begin
      if (keys_q[i] != code_word_q[12 - 4 * (i % 4) +: 4]) match = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_d   = cur_state;
    elapsed_d = e;
    keys_d    = keys_q;
    ec_d      = ec_q;
    held_d    = held_q;
    fc_d      = fc_q;
    lit_d     = lit_q;
    rsd_d     = rsd_q;
    walk_d    = walk_q;
    unique case (cur_state)
      ST_INPUT: begin
        if (press) begin
          held_d = 1'b1;
          if (ec_q < EcW'(CODE_DIGITS)) begin
            for (int i = 0; i < CODE_DIGITS; i++) begin
              if (ec_q == EcW'(i)) keys_d[i] = s_axis_tdata[4:1];
            end
            ec_d = ec_q + EcW'(1);
            if (ec_q == EcW'(CODE_DIGITS - 1)) begin
              state_d   = ST_WAIT;
              elapsed_d = 8'd0;
            end
          end
        end else if (!s_axis_tdata[0] && held_q) begin
          held_d = 1'b0;
        end
      end
      ST_WAIT: begin
        if (e >= 8'(wait_ticks_q)) begin
          elapsed_d = 8'd0;
          if (match) begin
            state_d = ST_OPEN;
          end else begin
            state_d = ST_NO;
            fc_d    = 3'd0;
            lit_d   = 1'b1;
            rsd_d   = 1'b0;
          end
        end
      end
      ST_OPEN: ;
      ST_NO: begin
        if (!rsd_q && e == 8'd3) rsd_d = 1'b1;
        lit_d = lit_nxt;
        fc_d  = fc_nxt;
        if (no_exit) begin
          for (int i = 0; i < CODE_DIGITS; i++) keys_d[i] = KeyBlank;
          ec_d      = '0;
          state_d   = ST_INPUT;
          elapsed_d = 8'd0;
        end
      end
      ST_START: begin
        if (e >= 8'd20 && e < 8'd76) begin
          if (!walk_a[0]) walk_d = {walk_dig, WalkCodes[walk_rem]};
        end else if (e >= 8'd80) begin
          for (int i = 0; i < CODE_DIGITS; i++) keys_d[i] = KeyBlank;
          ec_d      = '0;
          state_d   = ST_INPUT;
          elapsed_d = 8'd0;
        end
      end
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    disp  = DISP_BLANK;
    tone  = TONE_OFF;
    relay = 1'b0;
    unique case (cur_state)
      ST_INPUT: begin
        disp = DISP_DIGIT;
        if (press) tone = TONE_440;
      end
      ST_WAIT: disp = DISP_DIGIT;
      ST_OPEN: begin
        disp  = DISP_OPEN;
        relay = 1'b1;
        if (e < 8'd2)      tone = TONE_554;
        else if (e < 8'd4) tone = TONE_659;
        else if (e < 8'd6) tone = TONE_880;
      end
      ST_NO: begin
        if (no_exit) begin
          disp = DISP_DIGIT;
        end else begin
          disp = lit_nxt ? DISP_NO : DISP_BLANK;
          if (!rsd_q && e < 8'd2)      tone = TONE_523;
          else if (!rsd_q && e < 8'd3) tone = TONE_370;
        end
      end
      ST_START: begin
        if (e < 8'd20) begin
          disp = DISP_ALL;
        end else if (e < 8'd76) begin
          disp = DISP_WALK;
        end else if (e < 8'd80) begin
          disp = DISP_BLANK;
          tone = (e < 8'd78) ? TONE_440 : TONE_880;
        end else begin
          disp = DISP_DIGIT;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    shown = '0;
    for (int i = 0; i < 4; i++) begin
      shown[12 - 4 * i +: 4] = (i < CODE_DIGITS) ? keys_d[i % CODE_DIGITS] : KeyBlank;
    end
  end

  always_comb begin
    res.display_mode  = disp;
    res.shown_digits  = (disp == DISP_DIGIT) ? shown : 16'd0;
    res.walk_digit    = (disp == DISP_WALK) ? walk_d[8:7] : 2'd0;
    res.walk_segments = (disp == DISP_WALK) ? walk_d[6:0] : 7'd0;
    res.tone_select   = tone;
    res.relay_on      = relay;
    res.done_signal   = relay;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_START;
      elapsed_q <= 8'd0;
      for (int i = 0; i < CODE_DIGITS; i++) keys_q[i] <= KeyBlank;
      ec_q      <= '0;
      held_q    <= 1'b0;
      fc_q      <= 3'd0;
      lit_q     <= 1'b1;
      rsd_q     <= 1'b0;
      walk_q    <= 9'd0;
    end else if (s_acc) begin
      state_q   <= state_d;
      elapsed_q <= elapsed_d;
      keys_q    <= keys_d;
      ec_q      <= ec_d;
      held_q    <= held_d;
      fc_q      <= fc_d;
      lit_q     <= lit_d;
      rsd_q     <= rsd_d;
      walk_q    <= walk_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s_acc) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) m_data_q <= OutDataW'(res);
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule
